### design/mrtp_pkg.sv
// Shared constants, codes and types of the modem response token parser.
package mrtp_pkg;

	// Sizes of the text stores.
	localparam int TOKEN_CHARS = 29;
	localparam int PHONE_CHARS = 12;
	localparam int CMD_CHARS   = 16;

	// Character slots on the result ports.
	localparam int PHONE_PORT_CHARS = 12;
	localparam int CMD_PORT_CHARS   = 16;

	// Only the leading characters of a token are ever read back.
	localparam int TOK_WIDEST = (PHONE_CHARS > CMD_CHARS) ? PHONE_CHARS : CMD_CHARS;
	localparam int TOK_KEEP   = (TOK_WIDEST < TOKEN_CHARS) ? TOK_WIDEST : TOKEN_CHARS;

	localparam int TOK_LEN_W   = $clog2(TOKEN_CHARS + 1);
	localparam int PHONE_CNT_W = $clog2(PHONE_CHARS + 1);
	localparam int CMD_CNT_W   = $clog2(CMD_CHARS + 1);

	// Byte codes.
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;
	localparam logic [7:0] SEP_FULL = 8'h01;
	localparam logic [7:0] SEP_NONE = 8'h00;

	// Keywords, first character in the most significant byte.
	localparam logic [39:0] KW_CALL = "+CLCC";
	localparam logic [39:0] KW_NOTE = "+CMTI";
	localparam logic [39:0] KW_READ = "+CMGR";
	localparam logic [15:0] KW_SM   = "SM";
	localparam logic [15:0] KW_OK   = "OK";
	localparam logic [7:0]  KW_FOUR = "4";

	// Field positions that the mode machine looks at.
	localparam logic [7:0] FLD_CALL_STATE = 8'd3;
	localparam logic [7:0] FLD_CALL_PHONE = 8'd6;
	localparam logic [7:0] FLD_NOTE_STORE = 8'd1;
	localparam logic [7:0] FLD_READ_PHONE = 8'd2;

	// Result codes.
	localparam logic [1:0] ACT_CALL  = 2'd0;
	localparam logic [1:0] ACT_NOTE  = 2'd1;
	localparam logic [1:0] ACT_CMD   = 2'd2;
	localparam logic [1:0] ACT_NOCMD = 2'd3;

	typedef enum logic [3:0] {
		MODE_IDLE          = 4'd0,
		MODE_SMS_NOTE      = 4'd1,
		MODE_SMS_NOTE_DONE = 4'd2,
		MODE_READ_HEAD     = 4'd3,
		MODE_READ_BODY     = 4'd4,
		MODE_READ_CMD      = 4'd5,
		MODE_READ_NOCMD    = 4'd6,
		MODE_CALL          = 4'd7,
		MODE_CALL_DONE     = 4'd8
	} mode_t;

endpackage

### design/modem_response_token_parser_unit.sv
// Modem response token parser: byte in, call and SMS notices out.
//
//   channel  | handshake          | payload
//   ---------+--------------------+-----------------------------------------------
//   input    | in_valid, in_stall | rx_char
//   output   | out_valid,out_stall| action, phone_head, phone_tail, phone_len,
//            |                    | cmd_head, cmd_tail, cmd_len
//
// A result is registered: its item is first held in the input register, and the token
// compare and mode update run combinationally from there into the result register, so
// a stall on the output can hold the item between the two.
// One item is accepted every cycle while no result waits under out_stall; the single
// combinational path through the keyword compares and the mode machine sets that figure.
// Reset clears the token length, mode, field count, separator and text counts; the
// text stores themselves are not reset and are only read below their counts.
// While a result waits under out_stall, the input register holds its item and
// in_stall is high whenever that register is occupied, whether or not the held
// item would produce a result.

module modem_response_token_parser_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_char,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  action,
	output logic [63:0] phone_head,
	output logic [31:0] phone_tail,
	output logic [3:0]  phone_len,
	output logic [63:0] cmd_head,
	output logic [63:0] cmd_tail,
	output logic [4:0]  cmd_len
);

	localparam int TLW = mrtp_pkg::TOK_LEN_W;
	localparam int PCW = mrtp_pkg::PHONE_CNT_W;
	localparam int CCW = mrtp_pkg::CMD_CNT_W;

	// Input register.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       in_accept;
	logic       adv;

	// Parser state.
	logic [7:0]           tok_q [mrtp_pkg::TOK_KEEP];
	logic [TLW-1:0]       tok_len_q;
	mrtp_pkg::mode_t      mode_q;
	logic [7:0]           field_q;
	logic [7:0]           prev_sep_q;
	logic [7:0]           phone_q [mrtp_pkg::PHONE_CHARS];
	logic [PCW-1:0]       phone_cnt_q;
	logic [7:0]           cmd_q [mrtp_pkg::CMD_CHARS];
	logic [CCW-1:0]       cmd_cnt_q;

	// Result register.
	logic        out_valid_q;
	logic [1:0]  action_q;
	logic [63:0] phone_head_q;
	logic [31:0] phone_tail_q;
	logic [3:0]  phone_len_q;
	logic [63:0] cmd_head_q;
	logic [63:0] cmd_tail_q;
	logic [4:0]  cmd_len_q;

	// Byte classification and token view.
	logic           is_sep;
	logic           is_drop;
	logic           app;
	logic [TLW-1:0] len_inc;
	logic           full;
	logic           end_tok;
	logic [7:0]     sep;
	logic [TLW-1:0] eff_len;
	logic [7:0]     tv [mrtp_pkg::TOK_KEEP];
	logic           m_call, m_note, m_read, m_sm, m_ok, m_four;
	logic [PCW-1:0] pc_copy;
	logic [CCW-1:0] cc_copy;

	// Mode machine results.
	mrtp_pkg::mode_t mode_n;
	logic [7:0]      field_n;
	logic [7:0]      prev_n;
	logic [PCW-1:0]  pc_n;
	logic [CCW-1:0]  cc_n;
	logic            copy_phone;
	logic            copy_cmd;
	logic            emit_c;
	logic [1:0]      act_c;
	logic [PCW-1:0]  pc_rep;
	logic [CCW-1:0]  cc_rep;

	logic [7:0] ph_n [mrtp_pkg::PHONE_CHARS];
	logic [7:0] cm_n [mrtp_pkg::CMD_CHARS];
	logic [7:0] ph_pad [mrtp_pkg::PHONE_PORT_CHARS];
	logic [7:0] cm_pad [mrtp_pkg::CMD_PORT_CHARS];

	// Handshake. The held item moves on whenever the result register can take a result.
	assign adv       = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !adv;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_accept || (valid_s1 && !adv);
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			byte_s1 <= rx_char;
		end
	end

	// Token cutting. A separator ends the token; a plain byte is appended and ends
	// the token with the full separator when it fills the token.
	always_comb begin
		is_sep  = (byte_s1 inside {mrtp_pkg::CH_NL, mrtp_pkg::CH_COMMA, mrtp_pkg::CH_COLON,
			mrtp_pkg::CH_LPAR, mrtp_pkg::CH_RPAR});
		is_drop = (byte_s1 inside {mrtp_pkg::CH_CR, mrtp_pkg::CH_SPACE, mrtp_pkg::CH_QUOTE});
		app     = !is_sep && !is_drop;
		len_inc = tok_len_q + TLW'(1);
		full    = app && (len_inc == TLW'(mrtp_pkg::TOKEN_CHARS));
		end_tok = is_sep || full;
		sep     = is_sep ? byte_s1 : mrtp_pkg::SEP_FULL;
		eff_len = full ? TLW'(mrtp_pkg::TOKEN_CHARS) : tok_len_q;
	end

	// The byte being appended is visible in the kept leading characters at once, so a token
	// ended by that byte is compared and copied as it then stands.
	always_comb begin
		for (int i = 0; i < mrtp_pkg::TOK_KEEP; i++) begin
			tv[i] = (app && tok_len_q == TLW'(i)) ? byte_s1 : tok_q[i];
		end
	end

	always_comb begin
		m_call = (eff_len == TLW'(5)) && ({tv[0], tv[1], tv[2], tv[3], tv[4]} == mrtp_pkg::KW_CALL);
		m_note = (eff_len == TLW'(5)) && ({tv[0], tv[1], tv[2], tv[3], tv[4]} == mrtp_pkg::KW_NOTE);
		m_read = (eff_len == TLW'(5)) && ({tv[0], tv[1], tv[2], tv[3], tv[4]} == mrtp_pkg::KW_READ);
		m_sm   = (eff_len == TLW'(2)) && ({tv[0], tv[1]} == mrtp_pkg::KW_SM);
		m_ok   = (eff_len == TLW'(2)) && ({tv[0], tv[1]} == mrtp_pkg::KW_OK);
		m_four = (eff_len == TLW'(1)) && (tv[0] == mrtp_pkg::KW_FOUR);
		pc_copy = (int'(eff_len) > mrtp_pkg::PHONE_CHARS) ? PCW'(mrtp_pkg::PHONE_CHARS)
			: PCW'(eff_len);
		cc_copy = (int'(eff_len) > mrtp_pkg::CMD_CHARS) ? CCW'(mrtp_pkg::CMD_CHARS)
			: CCW'(eff_len);
	end

	// Mode machine, first pass: inspect the finished token.
	always_comb begin
		logic [7:0] sep_v;
		mode_n     = mode_q;
		field_n    = field_q + 8'd1;
		pc_n       = phone_cnt_q;
		cc_n       = cmd_cnt_q;
		copy_phone = 1'b0;
		copy_cmd   = 1'b0;
		sep_v      = sep;
		case (mode_q)
			mrtp_pkg::MODE_IDLE: begin
				if (sep == mrtp_pkg::CH_COLON) begin
					if (m_call) begin
						mode_n  = mrtp_pkg::MODE_CALL;
						field_n = 8'd0;
					end else if (m_note) begin
						mode_n  = mrtp_pkg::MODE_SMS_NOTE;
						field_n = 8'd0;
					end else if (m_read) begin
						mode_n  = mrtp_pkg::MODE_READ_HEAD;
						field_n = 8'd0;
					end
				end
			end
			mrtp_pkg::MODE_CALL: begin
				if (field_n == mrtp_pkg::FLD_CALL_STATE && !m_four) begin
					// A call in any state but incoming is dropped.
					mode_n  = mrtp_pkg::MODE_IDLE;
					field_n = 8'd0;
					pc_n    = '0;
					cc_n    = '0;
					sep_v   = mrtp_pkg::SEP_NONE;
				end else if (field_n == mrtp_pkg::FLD_CALL_PHONE) begin
					copy_phone = 1'b1;
					pc_n       = pc_copy;
				end else if (sep == mrtp_pkg::CH_NL) begin
					mode_n  = mrtp_pkg::MODE_CALL_DONE;
					field_n = 8'd0;
				end
			end
			mrtp_pkg::MODE_SMS_NOTE: begin
				if (field_n == mrtp_pkg::FLD_NOTE_STORE && !m_sm) begin
					mode_n  = mrtp_pkg::MODE_IDLE;
					field_n = 8'd0;
					pc_n    = '0;
					cc_n    = '0;
					sep_v   = mrtp_pkg::SEP_NONE;
				end else if (sep == mrtp_pkg::CH_NL) begin
					mode_n  = mrtp_pkg::MODE_SMS_NOTE_DONE;
					field_n = 8'd0;
				end
			end
			mrtp_pkg::MODE_READ_HEAD: begin
				if (field_n == mrtp_pkg::FLD_READ_PHONE) begin
					copy_phone = 1'b1;
					pc_n       = pc_copy;
				end else if (sep == mrtp_pkg::CH_NL) begin
					mode_n  = mrtp_pkg::MODE_READ_BODY;
					field_n = 8'd0;
				end
			end
			mrtp_pkg::MODE_READ_BODY: begin
				if (prev_sep_q == mrtp_pkg::CH_LPAR && sep == mrtp_pkg::CH_RPAR) begin
					copy_cmd = 1'b1;
					cc_n     = cc_copy;
					mode_n   = mrtp_pkg::MODE_READ_CMD;
					field_n  = 8'd0;
				end else if (sep == mrtp_pkg::CH_NL) begin
					mode_n  = mrtp_pkg::MODE_READ_NOCMD;
					field_n = 8'd0;
				end
			end
			default: begin
			end
		endcase
		prev_n = sep_v;
	end

	// Mode machine, second pass: completion and the result code.
	always_comb begin
		emit_c = 1'b0;
		act_c  = mrtp_pkg::ACT_CALL;
		case (mode_n)
			mrtp_pkg::MODE_CALL_DONE: begin
				emit_c = 1'b1;
				act_c  = mrtp_pkg::ACT_CALL;
			end
			mrtp_pkg::MODE_SMS_NOTE_DONE: begin
				emit_c = 1'b1;
				act_c  = mrtp_pkg::ACT_NOTE;
			end
			mrtp_pkg::MODE_READ_CMD: begin
				emit_c = (prev_n == mrtp_pkg::CH_NL) && m_ok;
				act_c  = mrtp_pkg::ACT_CMD;
			end
			mrtp_pkg::MODE_READ_NOCMD: begin
				emit_c = (prev_n == mrtp_pkg::CH_NL) && m_ok;
				act_c  = mrtp_pkg::ACT_NOCMD;
			end
			default: begin
			end
		endcase
		emit_c = emit_c && end_tok;
		pc_rep = pc_n;
		cc_rep = (act_c == mrtp_pkg::ACT_CMD) ? cc_n : '0;
	end

	// Text as it stands after this token, then packed with unused slots zeroed.
	always_comb begin
		for (int i = 0; i < mrtp_pkg::PHONE_CHARS; i++) begin
			ph_n[i] = copy_phone ? tv[i] : phone_q[i];
		end
		for (int i = 0; i < mrtp_pkg::CMD_CHARS; i++) begin
			cm_n[i] = copy_cmd ? tv[i] : cmd_q[i];
		end
	end

	for (genvar i = 0; i < mrtp_pkg::PHONE_PORT_CHARS; i++) begin : g_ph
		if (i < mrtp_pkg::PHONE_CHARS) begin : g_live
			assign ph_pad[i] = (PCW'(i) < pc_rep) ? ph_n[i] : 8'd0;
		end else begin : g_pad
			assign ph_pad[i] = 8'd0;
		end
	end

	for (genvar i = 0; i < mrtp_pkg::CMD_PORT_CHARS; i++) begin : g_cm
		if (i < mrtp_pkg::CMD_CHARS) begin : g_live
			assign cm_pad[i] = (CCW'(i) < cc_rep) ? cm_n[i] : 8'd0;
		end else begin : g_pad
			assign cm_pad[i] = 8'd0;
		end
	end

	// State update on every item that leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_len_q   <= '0;
			mode_q      <= mrtp_pkg::MODE_IDLE;
			field_q     <= 8'd0;
			prev_sep_q  <= mrtp_pkg::SEP_NONE;
			phone_cnt_q <= '0;
			cmd_cnt_q   <= '0;
		end else if (adv) begin
			if (end_tok) begin
				tok_len_q <= '0;
				if (emit_c) begin
					// Completion returns to idle and forgets the texts.
					mode_q      <= mrtp_pkg::MODE_IDLE;
					field_q     <= 8'd0;
					prev_sep_q  <= mrtp_pkg::SEP_NONE;
					phone_cnt_q <= '0;
					cmd_cnt_q   <= '0;
				end else if (mode_n == mrtp_pkg::MODE_CALL_DONE
					|| mode_n == mrtp_pkg::MODE_SMS_NOTE_DONE) begin
					mode_q      <= mrtp_pkg::MODE_IDLE;
					field_q     <= 8'd0;
					prev_sep_q  <= mrtp_pkg::SEP_NONE;
					phone_cnt_q <= '0;
					cmd_cnt_q   <= '0;
				end else begin
					mode_q      <= mode_n;
					field_q     <= field_n;
					prev_sep_q  <= prev_n;
					phone_cnt_q <= pc_n;
					cmd_cnt_q   <= cc_n;
				end
			end else if (app) begin
				tok_len_q <= len_inc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < mrtp_pkg::TOK_KEEP; i++) begin
				tok_q[i] <= tv[i];
			end
			if (end_tok) begin
				for (int i = 0; i < mrtp_pkg::PHONE_CHARS; i++) begin
					phone_q[i] <= ph_n[i];
				end
				for (int i = 0; i < mrtp_pkg::CMD_CHARS; i++) begin
					cmd_q[i] <= cm_n[i];
				end
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= adv && emit_c;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit_c) begin
			action_q    <= act_c;
			phone_len_q <= 4'(pc_rep);
			cmd_len_q   <= 5'(cc_rep);
			for (int i = 0; i < 8; i++) begin
				phone_head_q[8*i +: 8] <= ph_pad[i];
				cmd_head_q[8*i +: 8]   <= cm_pad[i];
				cmd_tail_q[8*i +: 8]   <= cm_pad[i+8];
			end
			for (int i = 0; i < 4; i++) begin
				phone_tail_q[8*i +: 8] <= ph_pad[i+8];
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign action     = action_q;
	assign phone_head = phone_head_q;
	assign phone_tail = phone_tail_q;
	assign phone_len  = phone_len_q;
	assign cmd_head   = cmd_head_q;
	assign cmd_tail   = cmd_tail_q;
	assign cmd_len    = cmd_len_q;

	// The token never rests at full length: a full token is always closed at once.
	a_tok_len: assert property (@(posedge clk) disable iff (!arst_n)
		int'(tok_len_q) < mrtp_pkg::TOKEN_CHARS)
		else $error("token length reached the full size");

	// Every result sends the machine back to idle with empty texts.
	a_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && emit_c) |=> (mode_q == mrtp_pkg::MODE_IDLE && phone_cnt_q == '0
			&& cmd_cnt_q == '0 && field_q == 8'd0))
		else $error("parser not idle after a result");

	// Command text is reported only with the command result.
	a_cmd_only: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && action_q != mrtp_pkg::ACT_CMD) |-> (cmd_len_q == 5'd0
			&& cmd_head_q == 64'd0 && cmd_tail_q == 64'd0))
		else $error("command text on a result without command");

	// A held item is not lost or overwritten while the result side is blocked.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |=> (valid_s1 && $stable(byte_s1)))
		else $error("held item changed under stall");

	// Reported lengths stay inside the stores.
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (int'(phone_len_q) <= mrtp_pkg::PHONE_CHARS
			&& int'(cmd_len_q) <= mrtp_pkg::CMD_CHARS))
		else $error("reported length beyond store size");

endmodule
